// ===== design/ps2mpc_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2mpc_pkg: shared constants for the PS/2 mouse packet cursor unit
// Header bit positions, byte phase codes and configuration register indexes.
// ----------------------------------------------------------------------------
package ps2mpc_pkg;

	// header byte bit positions
	localparam int HDR_LEFT  = 0;
	localparam int HDR_RIGHT = 1;
	localparam int HDR_ONE   = 3;
	localparam int HDR_XSIGN = 4;
	localparam int HDR_YSIGN = 5;
	localparam int HDR_XOVF  = 6;
	localparam int HDR_YOVF  = 7;

	// byte phase codes
	localparam logic [1:0] PH_HDR = 2'd0;
	localparam logic [1:0] PH_X   = 2'd1;
	localparam logic [1:0] PH_Y   = 2'd2;
	localparam logic [1:0] PH_BAD = 2'd3;

	// configuration port
	localparam int ADDR_BITS = 3;
	localparam int DATA_BITS = 32;
	localparam int SIZE_BITS = 13;
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 13'd1024;
	localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 13'd768;

endpackage

// ===== design/ps2_mouse_packet_cursor_unit.sv =====
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_unit: PS/2 mouse packet decoder with clamped cursor
// Assembles header, X and Y bytes into packets and moves a cursor that is
// clamped to the configured screen size.
// ----------------------------------------------------------------------------
// The unit takes one received byte per clock cycle and returns one word on
// the third byte of every packet: the clamped cursor position and the left
// and right button states. A header byte without bit 3 set is dropped. The
// movement, clamp and position update are done in the cycle the byte is
// taken, and the result sits in an output register, so input stalls only
// while that register is full and its word is stalled. screen_width lies at
// address 0 and screen_height at address 4; a new size applies to every packet
// completed after the write, and a size of zero counts as one.
module ps2_mouse_packet_cursor_unit #(
	parameter int COORD_BITS = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [ps2mpc_pkg::ADDR_BITS-1:0]     paddr,
	input  logic [ps2mpc_pkg::DATA_BITS-1:0]     pwdata,
	output logic [ps2mpc_pkg::DATA_BITS-1:0]     prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [7:0]                           rx_byte,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [COORD_BITS-1:0]                cursor_x,
	output logic [COORD_BITS-1:0]                cursor_y,
	output logic                                 left_button,
	output logic                                 right_button
);

	localparam int SW = COORD_BITS + 4;
	localparam logic [31:0] SPAN = 32'd1 << COORD_BITS;

	logic [ps2mpc_pkg::SIZE_BITS-1:0] width_q, height_q;
	logic [1:0]                       phase_q;
	logic [7:0]                       header_q, xbyte_q;
	logic [COORD_BITS-1:0]            pos_x_q, pos_y_q;
	logic                             out_valid_q;
	logic [COORD_BITS-1:0]            res_x_s1, res_y_s1;
	logic                             res_left_s1, res_right_s1;

	logic                             in_acc, pkt_done, cfg_wr;
	logic signed [SW-1:0]             dx, dy, sum_x, sum_y;
	logic [COORD_BITS-1:0]            next_x, next_y;

	function automatic logic signed [SW-1:0] move(input logic [7:0] mag, input logic neg,
		input logic ovf);
		logic signed [SW-1:0] d;
		d = neg ? $signed({{(SW-8){1'b1}}, mag}) : $signed({{(SW-8){1'b0}}, mag});
		if (ovf) begin
			d = neg ? d - $signed(SW'(255)) : d + $signed(SW'(255));
		end
		return d;
	endfunction

	function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SW-1:0] v,
		input logic [ps2mpc_pkg::SIZE_BITS-1:0] size);
		logic [31:0]           size32;
		logic [31:0]           lim32;
		logic [COORD_BITS-1:0] lim;
		logic [COORD_BITS-1:0] r;
		size32 = {{(32-ps2mpc_pkg::SIZE_BITS){1'b0}}, size};
		if (size32 == 32'd0) begin
			lim32 = 32'd0;
		end else if (size32 > SPAN) begin
			lim32 = SPAN - 32'd1;
		end else begin
			lim32 = size32 - 32'd1;
		end
		lim = lim32[COORD_BITS-1:0];
		if (v < 0) begin
			r = '0;
		end else if (v > $signed({{(SW-COORD_BITS){1'b0}}, lim})) begin
			r = lim;
		end else begin
			r = v[COORD_BITS-1:0];
		end
		return r;
	endfunction

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ps2mpc_pkg::WIDTH_RESET;
			height_q <= ps2mpc_pkg::HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				ps2mpc_pkg::REG_WIDTH:  width_q  <= pwdata[ps2mpc_pkg::SIZE_BITS-1:0];
				ps2mpc_pkg::REG_HEIGHT: height_q <= pwdata[ps2mpc_pkg::SIZE_BITS-1:0];
				default:                width_q  <= width_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			ps2mpc_pkg::REG_WIDTH:
				prdata = {{(ps2mpc_pkg::DATA_BITS-ps2mpc_pkg::SIZE_BITS){1'b0}}, width_q};
			default:
				prdata = {{(ps2mpc_pkg::DATA_BITS-ps2mpc_pkg::SIZE_BITS){1'b0}}, height_q};
		endcase
	end

	// handshake
	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;
	assign pkt_done = in_acc && (phase_q == ps2mpc_pkg::PH_Y);

	// movement and clamp
	assign dx = move(xbyte_q, header_q[ps2mpc_pkg::HDR_XSIGN], header_q[ps2mpc_pkg::HDR_XOVF]);
	assign dy = move(rx_byte, header_q[ps2mpc_pkg::HDR_YSIGN], header_q[ps2mpc_pkg::HDR_YOVF]);
	assign sum_x = $signed({{(SW-COORD_BITS){1'b0}}, pos_x_q}) + dx;
	assign sum_y = $signed({{(SW-COORD_BITS){1'b0}}, pos_y_q}) - dy;
	assign next_x = clamp(sum_x, width_q);
	assign next_y = clamp(sum_y, height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ps2mpc_pkg::PH_HDR;
			header_q <= '0;
			xbyte_q  <= '0;
			pos_x_q  <= '0;
			pos_y_q  <= '0;
		end else if (in_acc) begin
			unique case (phase_q)
				ps2mpc_pkg::PH_X: begin
					xbyte_q <= rx_byte;
					phase_q <= ps2mpc_pkg::PH_Y;
				end
				ps2mpc_pkg::PH_Y: begin
					pos_x_q <= next_x;
					pos_y_q <= next_y;
					phase_q <= ps2mpc_pkg::PH_HDR;
				end
				default: begin
					if (rx_byte[ps2mpc_pkg::HDR_ONE]) begin
						header_q <= rx_byte;
						phase_q  <= ps2mpc_pkg::PH_X;
					end else begin
						phase_q  <= ps2mpc_pkg::PH_HDR;
					end
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pkt_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_done) begin
			res_x_s1     <= next_x;
			res_y_s1     <= next_y;
			res_left_s1  <= header_q[ps2mpc_pkg::HDR_LEFT];
			res_right_s1 <= header_q[ps2mpc_pkg::HDR_RIGHT];
		end
	end

	assign out_valid    = out_valid_q;
	assign cursor_x     = res_x_s1;
	assign cursor_y     = res_y_s1;
	assign left_button  = res_left_s1;
	assign right_button = res_right_s1;

	// checks
	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != ps2mpc_pkg::PH_BAD)
		else $error("byte phase reached unused code");

	a_word_only_on_y: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && phase_q != ps2mpc_pkg::PH_Y && !(out_valid_q && out_stall)) |=> !out_valid)
		else $error("word issued without a completed packet");

	a_pos_matches_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pos_x_q == res_x_s1 && pos_y_q == res_y_s1))
		else $error("held word differs from cursor position");

endmodule
